[design/rpa_pkg.sv]
// Shared types, codes and constants of the rolling plot autoscale renderer.
package rpa_pkg;

	// Width of the product of a sample and the plot height, and of the divider.
	localparam int DIV_W = 22;
	// Width of the divisor and remainder in the divider.
	localparam int DVS_W = 12;

	// Largest vertical scale.
	localparam logic [11:0] SCALE_LIMIT = 12'd4095;

	// Register reset values.
	localparam logic [11:0] RST_INITIAL_SCALE = 12'd200;
	localparam logic [11:0] RST_SCALE_STEP    = 12'd20;
	localparam logic [9:0]  RST_X_ORIGIN      = 10'd35;
	localparam logic [3:0]  RST_X_STEP        = 4'd2;
	localparam logic [9:0]  RST_Y_ORIGIN      = 10'd10;
	localparam logic [9:0]  RST_PLOT_HEIGHT   = 10'd150;

	// Configuration register indexes.
	localparam logic [2:0] REG_AUTO_RANGE    = 3'd0;
	localparam logic [2:0] REG_INITIAL_SCALE = 3'd1;
	localparam logic [2:0] REG_SCALE_STEP    = 3'd2;
	localparam logic [2:0] REG_X_ORIGIN      = 3'd3;
	localparam logic [2:0] REG_X_STEP        = 3'd4;
	localparam logic [2:0] REG_Y_ORIGIN      = 3'd5;
	localparam logic [2:0] REG_PLOT_HEIGHT   = 3'd6;

	// Result kinds.
	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Request to the shared divider.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	// Response of the shared divider.
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DVS_W-1:0] remainder;
	} div_rsp_t;

	// Sequencer states of the top level.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG_DIV,
		ST_AVG_WAIT,
		ST_STEP_DIV,
		ST_STEP_WAIT,
		ST_WRAP_CLR,
		ST_CLR_TOKEN,
		ST_RD,
		ST_PT_MUL,
		ST_PT_DIV,
		ST_PT_WAIT,
		ST_EMIT
	} state_t;

endpackage

[design/rpa_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module rpa_div (
	input  logic            clk,
	input  logic            arst_n,
	input  rpa_pkg::div_req_t req,
	output rpa_pkg::div_rsp_t rsp
);
	import rpa_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic             fits;
	logic [DVS_W-1:0] rem_next;

	// One restoring step: shift in the next dividend bit and try a subtraction.
	always_comb begin
		trial    = {rem_q, quo_q[DIV_W-1]};
		fits     = trial >= {1'b0, dvs_q};
		rem_next = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift registers of the quotient and the partial remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

[design/rolling_plot_autoscale_renderer_top.sv]
// Top level of the rolling plot autoscale renderer: sample ring, sequencer and output register.
//
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       s_tdata: sample
// m_*       out        m_tvalid / m_tready       m_tdata: coordinates and scale, m_tuser: kind,
//                                                m_tlast: last result of the sample
// cfg_*     in         cfg_valid / cfg_ready     cfg_index: register index, cfg_data: value
//
// Every point is mapped by one multiply and a 22-step bit-serial division in rpa_div.
// During the first pass a sample maps one point. Once the ring is full a sample redraws
// the whole window of DEPTH points after a clear token, with a clearing step at a wrap,
// and an average and a rounding division at a wrap with automatic range, since both share the divider.
// There is no clearing pass after reset. A stalled output holds the sequencer only
// when a new result must be loaded while the output register is still full.
module rolling_plot_autoscale_renderer_top #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [11:0] x_start, [22:12] y_start, [34:23] x_finish,
	                               // [45:35] y_finish, [57:46] scale_now
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import rpa_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int SUM_W = $clog2((DEPTH + 1) * 4095);

	// Configuration registers.
	logic        auto_range_q;
	logic [11:0] initial_scale_q;
	logic [11:0] scale_step_q;
	logic [9:0]  x_origin_q;
	logic [3:0]  x_step_q;
	logic [9:0]  y_origin_q;
	logic [9:0]  plot_height_q;

	// Block state.
	state_t          state_q, state_d;
	logic [AW-1:0]   wpos_q;
	logic            full_q;
	logic [11:0]     max_q;
	logic [SUM_W-1:0] sum_q;
	logic [11:0]     scale_q;
	logic            prev_valid_q;
	logic [11:0]     prev_x_q;
	logic [10:0]     prev_y_q;

	// Per-sample working registers.
	logic [11:0]     v_q;
	logic [AW-1:0]   pos_q;
	logic            was_full_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   kcnt_q;
	logic [11:0]     col_q;
	logic [DIV_W-1:0] prod_q;
	logic [10:0]     cur_y_q;
	logic [11:0]     s_q;

	// Sample ring.
	logic [11:0]     ring_mem [DEPTH];
	logic [11:0]     rd_data_q;

	// Output register.
	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;

	// Shared divider.
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Combinational helpers.
	logic        s_acc;
	logic        wrap;
	logic        out_free;
	logic        out_load;
	logic [1:0]  out_kind;
	logic [11:0] out_xs, out_xf;
	logic [10:0] out_ys, out_yf;
	logic        out_last;
	logic [11:0] step_eff;
	logic [11:0] col_first;
	logic [9:0]  n_clamp;
	logic [10:0] row_d;
	logic [13:0] avg_sum;
	logic [11:0] scale_rounded;
	logic [11:0] v_src;
	logic        last_point;

	assign s_acc      = s_tvalid && s_tready;
	assign wrap       = full_q && (wpos_q == '0);
	assign out_free   = !m_tvalid_q || m_tready;
	assign step_eff   = (scale_step_q == '0) ? 12'd1 : scale_step_q;
	assign col_first  = 12'(x_origin_q) + 12'(12'(pos_q) * 12'(x_step_q));
	assign v_src      = was_full_q ? rd_data_q : v_q;
	assign last_point = kcnt_q == AW'(DEPTH - 1);
	assign cfg_ready  = 1'b1;

	// Row of a point from the divider quotient.
	always_comb begin
		if (div_rsp.quotient > {12'b0, plot_height_q}) begin
			n_clamp = plot_height_q;
		end else begin
			n_clamp = div_rsp.quotient[9:0];
		end
		row_d = {1'b0, y_origin_q} + {1'b0, plot_height_q} - {1'b0, n_clamp};
	end

	// Automatic scale: average plus maximum, clamped, then rounded down to the step, but never below one step.
	always_comb begin
		avg_sum       = {2'b0, max_q} + div_rsp.quotient[13:0];
		scale_rounded = s_q - div_rsp.remainder;
		if (scale_rounded == '0) begin
			scale_rounded = step_eff;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					priority if (wrap && auto_range_q) begin
						state_d = ST_AVG_DIV;
					end else if (wrap) begin
						state_d = ST_WRAP_CLR;
					end else if (full_q) begin
						state_d = ST_CLR_TOKEN;
					end else begin
						state_d = ST_PT_MUL;
					end
				end
			end
			ST_AVG_DIV:   state_d = ST_AVG_WAIT;
			ST_AVG_WAIT:  if (div_rsp.done) state_d = ST_STEP_DIV;
			ST_STEP_DIV:  state_d = ST_STEP_WAIT;
			ST_STEP_WAIT: if (div_rsp.done) state_d = ST_WRAP_CLR;
			ST_WRAP_CLR:  state_d = ST_CLR_TOKEN;
			ST_CLR_TOKEN: if (out_free) state_d = ST_RD;
			ST_RD:        state_d = ST_PT_MUL;
			ST_PT_MUL:    state_d = ST_PT_DIV;
			ST_PT_DIV:    state_d = ST_PT_WAIT;
			ST_PT_WAIT:   if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (!was_full_q) begin
					if (out_free) state_d = ST_IDLE;
				end else if (kcnt_q == '0 || out_free) begin
					state_d = last_point ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: input ready, divider requests and result loads.
	always_comb begin
		s_tready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = scale_q;
		out_load         = 1'b0;
		out_kind         = KIND_LINE;
		out_xs           = prev_x_q;
		out_ys           = prev_y_q;
		out_xf           = col_first;
		out_yf           = cur_y_q;
		out_last         = 1'b1;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_AVG_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(sum_q);
				div_req.divisor  = DVS_W'(DEPTH);
			end
			ST_STEP_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(s_q);
				div_req.divisor  = step_eff;
			end
			ST_PT_DIV: div_req.start = 1'b1;
			ST_CLR_TOKEN: begin
				out_load = out_free;
				out_kind = KIND_CLEAR;
				out_xs   = '0;
				out_ys   = '0;
				out_xf   = '0;
				out_yf   = '0;
				out_last = 1'b0;
			end
			ST_EMIT: begin
				if (!was_full_q) begin
					out_load = out_free;
					if (!prev_valid_q) begin
						out_kind = KIND_PIXEL;
						out_xs   = col_first;
						out_ys   = cur_y_q;
					end
				end else begin
					out_load = out_free && (kcnt_q != '0);
					out_xf   = col_q;
					out_last = last_point;
				end
			end
			default: ;
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_range_q    <= 1'b0;
			initial_scale_q <= RST_INITIAL_SCALE;
			scale_step_q    <= RST_SCALE_STEP;
			x_origin_q      <= RST_X_ORIGIN;
			x_step_q        <= RST_X_STEP;
			y_origin_q      <= RST_Y_ORIGIN;
			plot_height_q   <= RST_PLOT_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_AUTO_RANGE:    auto_range_q    <= cfg_data[0];
				REG_INITIAL_SCALE: initial_scale_q <= cfg_data;
				REG_SCALE_STEP:    scale_step_q    <= cfg_data;
				REG_X_ORIGIN:      x_origin_q      <= cfg_data[9:0];
				REG_X_STEP:        x_step_q        <= cfg_data[3:0];
				REG_Y_ORIGIN:      y_origin_q      <= cfg_data[9:0];
				REG_PLOT_HEIGHT:   plot_height_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Control state: sequencer, ring position, statistics and scale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wpos_q       <= '0;
			full_q       <= 1'b0;
			max_q        <= '0;
			sum_q        <= '0;
			scale_q      <= '0;
			prev_valid_q <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_acc) begin
				if (!full_q && wpos_q == '0) begin
					scale_q <= (initial_scale_q == '0) ? 12'd1 : initial_scale_q;
				end
				sum_q <= sum_q + SUM_W'(s_tdata[11:0]);
				if (s_tdata[11:0] > max_q) begin
					max_q <= s_tdata[11:0];
				end
				if (wpos_q == AW'(DEPTH - 1)) begin
					wpos_q <= '0;
					full_q <= 1'b1;
				end else begin
					wpos_q <= wpos_q + 1'b1;
				end
			end
			if (state_q == ST_STEP_WAIT && div_rsp.done) begin
				scale_q <= scale_rounded;
			end
			if (state_q == ST_WRAP_CLR) begin
				max_q        <= '0;
				sum_q        <= '0;
				prev_valid_q <= 1'b0;
			end
			// The last drawn point is the start of the next segment.
			if (state_q == ST_EMIT && !was_full_q && out_free) begin
				prev_x_q     <= col_first;
				prev_y_q     <= cur_y_q;
				prev_valid_q <= 1'b1;
			end else if (state_q == ST_EMIT && was_full_q && (kcnt_q == '0 || out_free)) begin
				prev_x_q <= col_q;
				prev_y_q <= cur_y_q;
			end
			// Output register: loaded by the sequencer, emptied by the sink.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current sample.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			v_q        <= s_tdata[11:0];
			pos_q      <= wpos_q;
			was_full_q <= full_q;
			idx_q      <= (wpos_q == AW'(DEPTH - 1)) ? '0 : wpos_q + 1'b1;
		end
		if (state_q == ST_AVG_WAIT && div_rsp.done) begin
			s_q <= (avg_sum > {2'b0, SCALE_LIMIT}) ? SCALE_LIMIT : avg_sum[11:0];
		end
		if (state_q == ST_CLR_TOKEN) begin
			col_q  <= 12'(x_origin_q);
			kcnt_q <= '0;
		end
		if (state_q == ST_PT_MUL) begin
			prod_q <= {10'b0, v_src} * {12'b0, plot_height_q};
		end
		if (state_q == ST_PT_WAIT && div_rsp.done) begin
			cur_y_q <= row_d;
		end
		// Step to the next point of the window.
		if (state_q == ST_EMIT && was_full_q && (kcnt_q == '0 || out_free)) begin
			col_q  <= col_q + 12'(x_step_q);
			kcnt_q <= kcnt_q + 1'b1;
			idx_q  <= (idx_q == AW'(DEPTH - 1)) ? '0 : idx_q + 1'b1;
		end
		if (out_load) begin
			m_tdata_q <= {6'b0, scale_q, out_yf, out_xf, out_ys, out_xs};
			m_tuser_q <= out_kind;
			m_tlast_q <= out_last;
		end
	end

	// Sample ring: one write port at the accepted transaction, one registered read port.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ring_mem[wpos_q] <= s_tdata[11:0];
		end
		rd_data_q <= ring_mem[idx_q];
	end

	rpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

[design/rpa_checker.sv]
// Port checker of the rolling plot autoscale renderer and its bind to the top level.
module rpa_assert (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import rpa_pkg::*;

	// A stalled result transaction keeps its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// The clear token has zero coordinates and never ends a sample's results.
	a_clear_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_CLEAR |-> m_tdata[45:0] == '0 && !m_tlast)
		else $error("malformed clear token");

	// A pixel starts and ends at one point and is the only result of its sample.
	a_pixel_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PIXEL |->
			m_tdata[11:0] == m_tdata[34:23] && m_tdata[22:12] == m_tdata[45:35] && m_tlast)
		else $error("malformed pixel");

	// The scale carried with any result has been loaded.
	a_scale_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[57:46] != '0)
		else $error("result with zero scale");

	// Only the three defined kinds appear.
	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == KIND_PIXEL || m_tuser == KIND_LINE || m_tuser == KIND_CLEAR)
		else $error("undefined result kind");

endmodule

bind rolling_plot_autoscale_renderer_top rpa_assert u_rpa_checker (.*);
